// ===== rtl/core/sltp_pkg.sv =====
// ----------------------------------------------------------------------------
// Script line token parser package
// Shared character constants, token kind codes, result types and the small
// character-class functions used by the scanner.
// ----------------------------------------------------------------------------
package sltp_pkg;

  localparam int CHAR_W = 8;
  localparam int KIND_W = 3;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [KIND_W-1:0] kind_t;

  // Token kinds carried on the result channel.
  localparam kind_t KIND_NAME_CHAR   = 3'd0;
  localparam kind_t KIND_NAME_END    = 3'd1;
  localparam kind_t KIND_PATH_CHAR   = 3'd2;
  localparam kind_t KIND_PATH_COMMIT = 3'd3;
  localparam kind_t KIND_PATH_DISC   = 3'd4;

  // Characters with a meaning of their own.
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_QUOTE = 8'h22;
  localparam char_t CH_HASH  = 8'h23;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_SEMI  = 8'h3B;
  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_BSL   = 8'h5C;
  localparam char_t CH_UNDER = 8'h5F;

  // Directive-name match tracker: 0..4 characters of the word matched, or failed.
  typedef logic [2:0] match_t;
  localparam match_t MM_EMPTY = 3'd0;
  localparam match_t MM_PATH  = 3'd4;
  localparam match_t MM_FAIL  = 3'd5;

  // One result beat.
  typedef struct packed {
    kind_t kind;
    char_t ch;
    logic  last;
  } tok_res_t;

  // Results raised by one step of the scanner: up to two beats.
  typedef struct packed {
    logic [1:0] cnt;
    tok_res_t   res0;
    tok_res_t   res1;
  } scan_out_t;

  // Letters of the directive word that selects the path value.
  function automatic char_t path_char(input logic [1:0] idx);
    char_t r;
    case (idx)
      2'd0:    r = 8'h70;
      2'd1:    r = 8'h61;
      2'd2:    r = 8'h74;
      default: r = 8'h68;
    endcase
    return r;
  endfunction

  function automatic logic is_alnum(input char_t c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_ws(input char_t c);
    return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ===== rtl/core/sltp_if.sv =====
// ----------------------------------------------------------------------------
// Script line token parser channels
// Valid/ready channels for script characters and for emitted tokens.
// ----------------------------------------------------------------------------
interface sltp_char_if;
  logic            valid;
  logic            ready;
  sltp_pkg::char_t char_code;
  logic            line_end;

  modport source (output valid, output char_code, output line_end, input ready);
  modport sink   (input valid, input char_code, input line_end, output ready);
endinterface

interface sltp_tok_if;
  logic            valid;
  logic            ready;
  sltp_pkg::kind_t token_kind;
  sltp_pkg::char_t token_char;
  logic            last;

  modport source (output valid, output token_kind, output token_char, output last,
                  input ready);
  modport sink   (input valid, input token_kind, input token_char, input last,
                  output ready);
endinterface

// ===== rtl/core/script_line_token_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Script line token parser
// Scans a script character by character, streaming experiment-name and path
// directive tokens to the result channel.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload                          Beat accepted when
//   in_ch    sink       char_code[7:0], line_end         valid && ready
//   out_ch   source     token_kind[2:0], token_char[7:0], last  valid && ready
//
// A character beat is registered on acceptance and parsed from the input
// register once the queue has room; its tokens are written into the result
// queue and are offered on the result channel from there.
// One beat per cycle is sustained while the result channel keeps up. A beat is
// parsed only when the four-entry result queue holds at most two tokens; each
// path commit that yields two tokens leaves one more token queued, so a second
// pair before the queue drains holds the input until there is room again.
// Reset is synchronous and active low; it returns the parser to line start
// and empties the queue. A stalled result channel back-pressures the input.
// ----------------------------------------------------------------------------
module script_line_token_parser_unit #(
  parameter int MAX_LINE_CHARS = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  sltp_char_if.sink  in_ch,
  sltp_tok_if.source out_ch
);
  import sltp_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE_CHARS + 1);

  logic      in_valid_r;
  char_t     in_char_r;
  logic      in_eol_r;
  logic      room;
  logic      step;
  logic      load;
  scan_out_t scan;

  // The registered beat is parsed once the queue has room for its results.
  assign step        = in_valid_r && room;
  assign in_ch.ready = !in_valid_r || step;
  assign load        = in_ch.valid && in_ch.ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_char_r <= in_ch.char_code;
      in_eol_r  <= in_ch.line_end;
    end
  end

  sltp_scanner #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .POS_W          (POS_W)
  ) u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .char_code (in_char_r),
    .line_end  (in_eol_r),
    .scan      (scan)
  );

  sltp_res_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .scan   (scan),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/core/sltp_scanner.sv =====
// ----------------------------------------------------------------------------
// Script line scanner
// Holds the per-line parse state and combinationally turns one registered
// character beat into zero, one or two token results.
// ----------------------------------------------------------------------------
module sltp_scanner #(
  parameter int MAX_LINE_CHARS = 256,
  parameter int POS_W          = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  sltp_pkg::char_t       char_code,
  input  logic                  line_end,
  output sltp_pkg::scan_out_t   scan
);
  import sltp_pkg::*;

  typedef enum logic [3:0] {
    ST_START,
    ST_COMMENT,
    ST_NAME,
    ST_AFTER_NAME,
    ST_DIR_PRE,
    ST_META,
    ST_DIR_GAP,
    ST_EQ,
    ST_VALUE,
    ST_QUOTED,
    ST_SKIP
  } state_t;

  state_t           state_r, state_nxt;
  match_t           mm_r, mm_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             lwb_r, lwb_nxt;
  logic             vs_r, vs_nxt;

  logic is_path;
  logic eol_name;
  logic eol_disc;

  assign is_path  = (mm_r == MM_PATH);
  assign eol_name = (state_r == ST_NAME);
  assign eol_disc = (state_r == ST_VALUE || state_r == ST_QUOTED) && is_path && vs_r;

  // Next state and results for the beat held in the input register.
  always_comb begin
    state_nxt = state_r;
    mm_nxt    = mm_r;
    pos_nxt   = pos_r;
    lwb_nxt   = lwb_r;
    vs_nxt    = vs_r;
    scan      = '0;

    if (step) begin
      if (line_end || (pos_r < POS_W'(MAX_LINE_CHARS) && char_code == CH_NUL)) begin
        // End of line, or a NUL that ends parsing for the rest of it.
        if (eol_name) begin
          scan.cnt  = 2'd1;
          scan.res0 = '{kind: KIND_NAME_END, ch: '0, last: 1'b1};
        end else if (eol_disc) begin
          scan.cnt  = 2'd1;
          scan.res0 = '{kind: KIND_PATH_DISC, ch: '0, last: 1'b1};
        end
        mm_nxt  = MM_EMPTY;
        lwb_nxt = 1'b0;
        vs_nxt  = 1'b0;
        if (line_end) begin
          state_nxt = ST_START;
          pos_nxt   = '0;
        end else begin
          state_nxt = ST_SKIP;
          pos_nxt   = pos_r + 1'b1;
        end
      end else if (pos_r < POS_W'(MAX_LINE_CHARS)) begin
        pos_nxt = pos_r + 1'b1;
        case (state_r)
          ST_START: begin
            if (char_code == CH_SPACE || char_code == CH_TAB) begin
              state_nxt = ST_START;
            end else if (char_code == CH_SEMI) begin
              state_nxt = ST_COMMENT;
            end else if (is_alnum(char_code)) begin
              state_nxt = ST_NAME;
              scan.cnt  = 2'd1;
              scan.res0 = '{kind: KIND_NAME_CHAR, ch: char_code, last: 1'b1};
            end else if (char_code == CH_HASH) begin
              mm_nxt    = MM_EMPTY;
              state_nxt = ST_DIR_PRE;
            end else begin
              state_nxt = ST_SKIP;
            end
          end
          ST_NAME: begin
            if (is_alnum(char_code) || char_code == CH_DASH || char_code == CH_UNDER) begin
              scan.cnt  = 2'd1;
              scan.res0 = '{kind: KIND_NAME_CHAR, ch: char_code, last: 1'b1};
            end else begin
              scan.cnt  = 2'd1;
              scan.res0 = '{kind: KIND_NAME_END, ch: '0, last: 1'b1};
              state_nxt = (char_code == CH_SEMI) ? ST_COMMENT : ST_AFTER_NAME;
            end
          end
          ST_AFTER_NAME: begin
            if (char_code == CH_SEMI) begin
              state_nxt = ST_COMMENT;
            end
          end
          ST_DIR_PRE, ST_META: begin
            if (state_r == ST_DIR_PRE && is_ws(char_code)) begin
              state_nxt = state_r;
            end else if (is_alnum(char_code)) begin
              // Track how much of the directive word has matched so far.
              if (mm_r < MM_PATH && char_code == path_char(mm_r[1:0])) begin
                mm_nxt = mm_r + 1'b1;
              end else begin
                mm_nxt = MM_FAIL;
              end
              state_nxt = ST_META;
            end else if (state_r == ST_META && is_ws(char_code)) begin
              state_nxt = ST_DIR_GAP;
            end else if (state_r == ST_META && char_code == CH_EQ) begin
              state_nxt = ST_EQ;
            end else begin
              state_nxt = ST_SKIP;
            end
          end
          ST_DIR_GAP, ST_EQ: begin
            if (is_ws(char_code)) begin
              state_nxt = state_r;
            end else if (state_r == ST_DIR_GAP && char_code == CH_EQ) begin
              state_nxt = state_r;
            end else if (char_code == CH_QUOTE) begin
              lwb_nxt   = 1'b0;
              vs_nxt    = 1'b0;
              state_nxt = ST_QUOTED;
            end else begin
              // First character of an unquoted value.
              lwb_nxt   = (char_code == CH_BSL);
              vs_nxt    = is_path;
              state_nxt = ST_VALUE;
              if (is_path) begin
                scan.cnt  = 2'd1;
                scan.res0 = '{kind: KIND_PATH_CHAR, ch: char_code, last: 1'b1};
              end
            end
          end
          ST_VALUE, ST_QUOTED: begin
            if ((state_r == ST_VALUE && (char_code == CH_SPACE || char_code == CH_TAB)) ||
                (state_r == ST_QUOTED && char_code == CH_QUOTE)) begin
              // Commit: append a backslash unless the value already ends in one.
              state_nxt = ST_SKIP;
              if (is_path) begin
                if (!lwb_r) begin
                  scan.cnt  = 2'd2;
                  scan.res0 = '{kind: KIND_PATH_CHAR, ch: CH_BSL, last: 1'b0};
                  scan.res1 = '{kind: KIND_PATH_COMMIT, ch: '0, last: 1'b1};
                end else begin
                  scan.cnt  = 2'd1;
                  scan.res0 = '{kind: KIND_PATH_COMMIT, ch: '0, last: 1'b1};
                end
              end
            end else begin
              lwb_nxt = (char_code == CH_BSL);
              if (is_path) begin
                vs_nxt    = 1'b1;
                scan.cnt  = 2'd1;
                scan.res0 = '{kind: KIND_PATH_CHAR, ch: char_code, last: 1'b1};
              end
            end
          end
          default: begin
            state_nxt = state_r;
          end
        endcase
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      mm_r    <= MM_EMPTY;
      pos_r   <= '0;
      lwb_r   <= 1'b0;
      vs_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mm_r    <= mm_nxt;
      pos_r   <= pos_nxt;
      lwb_r   <= lwb_nxt;
      vs_r    <= vs_nxt;
    end
  end

endmodule

// ===== rtl/core/sltp_res_queue.sv =====
// ----------------------------------------------------------------------------
// Token result queue
// Four-entry register queue that takes up to two result beats per cycle from
// the scanner and presents one beat per cycle on the result channel while it is ready.
// ----------------------------------------------------------------------------
module sltp_res_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  sltp_pkg::scan_out_t scan,
  output logic                room,
  sltp_tok_if.source          out_ch
);
  import sltp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tok_res_t         ent_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;
  tok_res_t         head;

  // Room for a full pair of results from the next scanner step.
  assign room = (count_r <= CNT_W'(DEPTH - 2));

  assign head              = ent_r[rd_ptr_r];
  assign out_ch.valid      = (count_r != '0);
  assign out_ch.token_kind = head.kind;
  assign out_ch.token_char = head.ch;
  assign out_ch.last       = head.last;
  assign pop               = out_ch.valid && out_ch.ready;

  // Pointer and fill arithmetic.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(scan.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(scan.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Result storage: the first beat at the write pointer, the second after it.
  always_ff @(posedge clk) begin
    if (scan.cnt != 2'd0) begin
      ent_r[wr_ptr_r] <= scan.res0;
    end
    if (scan.cnt == 2'd2) begin
      ent_r[wr_ptr_r + 1'b1] <= scan.res1;
    end
  end

endmodule

// ===== rtl/core/sltp_checker.sv =====
// ----------------------------------------------------------------------------
// Script line token parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module sltp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            out_valid,
  input logic            out_ready,
  input sltp_pkg::kind_t out_kind,
  input sltp_pkg::char_t out_char,
  input logic            out_last
);
  import sltp_pkg::*;

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_char) && $stable(out_last))
    else $error("result beat changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending straight after reset");

  // The second beat of a pair is queued together with the first.
  a_pair_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second beat of a token pair missing");

  // Only character tokens carry a character, and every token kind is a known one.
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_NAME_CHAR && out_kind != KIND_PATH_CHAR |->
      out_char == '0 && (out_kind == KIND_NAME_END || out_kind == KIND_PATH_COMMIT ||
                         out_kind == KIND_PATH_DISC))
    else $error("bad token kind or stray character");

endmodule

bind script_line_token_parser_unit sltp_checker u_sltp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.token_kind),
  .out_char  (out_ch.token_char),
  .out_last  (out_ch.last)
);
